FILE: sv/aled_pkg.sv
// ----------------------------------------------------------------------------
// aled_pkg
// shared types and constants for the addressable led bit encoder
// ----------------------------------------------------------------------------
package aled_pkg;

    localparam int unsigned ChanWidth   = 8;
    localparam int unsigned PctWidth    = 7;
    localparam int unsigned DutyWidth   = 8;
    localparam int unsigned CfgIdxWidth = 2;
    localparam int unsigned CfgDatWidth = 8;

    localparam int unsigned BitsPerPixel = 24;
    localparam int unsigned CntWidth     = 5;

    // channel * percent, at most 255 * 127
    localparam int unsigned ProdWidth  = ChanWidth + PctWidth;
    // x / 100 == (x * 5243) >> 19, exact for every x below 2**15
    localparam int unsigned RecipK     = 5243;
    localparam int unsigned RecipWidth = 13;
    localparam int unsigned RecipShift = 19;
    localparam int unsigned QuotWidth  = ProdWidth + RecipWidth;
    localparam int unsigned ScaledWidth = ChanWidth + 1;

    typedef enum logic [CfgIdxWidth-1:0] {
        CFG_BRIGHTNESS = 2'd0,
        CFG_DUTY_ONE   = 2'd1,
        CFG_DUTY_ZERO  = 2'd2
    } t_cfg_idx;

    localparam logic [PctWidth-1:0]  BrightnessReset = 7'd100;
    localparam logic [DutyWidth-1:0] DutyOneReset    = 8'd50;
    localparam logic [DutyWidth-1:0] DutyZeroReset   = 8'd75;

    typedef logic [ChanWidth-1:0] t_chan;
    typedef logic [ProdWidth-1:0] t_prod;
    typedef logic [QuotWidth-1:0] t_quot;

endpackage

FILE: sv/aled_pix_if.sv
// ----------------------------------------------------------------------------
// aled_pix_if
// pixel channel: one rgb pixel plus its last-pixel flag per transaction
// ----------------------------------------------------------------------------
interface aled_pix_if;
    logic       valid;
    logic       ready;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last_pixel;

    modport source (output valid, output red, output green, output blue,
                    output last_pixel, input ready);
    modport sink   (input valid, input red, input green, input blue,
                    input last_pixel, output ready);
endinterface

FILE: sv/aled_bit_if.sv
// ----------------------------------------------------------------------------
// aled_bit_if
// bit channel: one pwm compare value per transaction
// ----------------------------------------------------------------------------
interface aled_bit_if;
    logic       valid;
    logic       ready;
    logic [7:0] compare_value;
    logic       end_of_run;

    modport source (output valid, output compare_value, output end_of_run,
                    input ready);
    modport sink   (input valid, input compare_value, input end_of_run,
                    output ready);
endinterface

FILE: sv/addressable_led_bit_encoder.sv
// ----------------------------------------------------------------------------
// addressable_led_bit_encoder
// scales a pixel by brightness and serializes it into pwm compare values
// ----------------------------------------------------------------------------
// Each accepted pixel gives 24 compare values in green, red, blue order, msb
// first (duty_for_one for a one bit, duty_for_zero for a zero bit); a pixel
// flagged last gives a 25th value of 0 with end_of_run set. Brightness is
// applied as floor(channel * percent / 100), saturating at 255, in a three
// stage pipeline (multiply, reciprocal multiply, saturate and pack) ahead of
// the serializer. The serializer emits one value per cycle while o_bit.ready
// is high, and loads the next pixel as the final value of the previous one is
// taken. A pixel passes stages 1, 2 and 3, then the shift register; the
// pipeline buffers up to three pixels while the serializer is busy.
module addressable_led_bit_encoder (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [aled_pkg::CfgIdxWidth-1:0] i_cfg_idx,
    input  logic [aled_pkg::CfgDatWidth-1:0] i_cfg_data,
    aled_pix_if.sink                        i_pix,
    aled_bit_if.source                      o_bit
);
    import aled_pkg::*;

    logic [PctWidth-1:0]  r_pct;
    logic [DutyWidth-1:0] r_duty_one;
    logic [DutyWidth-1:0] r_duty_zero;

    // stage 1: channel * percent
    logic  r_s1_valid;
    t_prod r_s1_r, r_s1_g, r_s1_b;
    logic  r_s1_last;
    // stage 2: times reciprocal of 100
    logic  r_s2_valid;
    t_quot r_s2_r, r_s2_g, r_s2_b;
    logic  r_s2_last;
    // stage 3: saturated and packed g,r,b word
    logic                      r_s3_valid;
    logic [BitsPerPixel-1:0]   r_s3_word;
    logic                      r_s3_last;
    // serializer
    logic                      r_busy;
    logic [BitsPerPixel-1:0]   r_shift;
    logic [CntWidth-1:0]       r_cnt;
    logic                      r_last;

    logic s1_adv, s2_adv, s3_adv, ser_load, out_fire, last_beat, trailer;
    logic [BitsPerPixel-1:0] n_word;

    function automatic t_chan sat_chan(input t_quot q);
        logic [ScaledWidth-1:0] v;
        begin
            v = q[RecipShift +: ScaledWidth];
            sat_chan = v[ScaledWidth-1] ? '1 : v[ChanWidth-1:0];
        end
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pct       <= BrightnessReset;
            r_duty_one  <= DutyOneReset;
            r_duty_zero <= DutyZeroReset;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_BRIGHTNESS: r_pct       <= i_cfg_data[PctWidth-1:0];
                CFG_DUTY_ONE:   r_duty_one  <= i_cfg_data[DutyWidth-1:0];
                CFG_DUTY_ZERO:  r_duty_zero <= i_cfg_data[DutyWidth-1:0];
                default: ;
            endcase
        end
    end

    assign trailer   = (r_cnt == CntWidth'(BitsPerPixel));
    assign out_fire  = r_busy && o_bit.ready;
    assign last_beat = trailer || (!r_last && r_cnt == CntWidth'(BitsPerPixel - 1));
    assign ser_load  = r_s3_valid && (!r_busy || (out_fire && last_beat));
    assign s3_adv    = r_s2_valid && (!r_s3_valid || ser_load);
    assign s2_adv    = r_s1_valid && (!r_s2_valid || s3_adv);
    assign s1_adv    = i_pix.valid && i_pix.ready;

    assign i_pix.ready = !r_s1_valid || s2_adv;

    assign n_word = {sat_chan(r_s2_g), sat_chan(r_s2_r), sat_chan(r_s2_b)};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
        end else begin
            if (i_pix.ready) begin
                r_s1_valid <= i_pix.valid;
            end
            if (!r_s2_valid || s3_adv) begin
                r_s2_valid <= r_s1_valid;
            end
            if (!r_s3_valid || ser_load) begin
                r_s3_valid <= r_s2_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_s1_r    <= ProdWidth'(i_pix.red)   * ProdWidth'(r_pct);
            r_s1_g    <= ProdWidth'(i_pix.green) * ProdWidth'(r_pct);
            r_s1_b    <= ProdWidth'(i_pix.blue)  * ProdWidth'(r_pct);
            r_s1_last <= i_pix.last_pixel;
        end
        if (s2_adv) begin
            r_s2_r    <= QuotWidth'(r_s1_r) * QuotWidth'(RecipK);
            r_s2_g    <= QuotWidth'(r_s1_g) * QuotWidth'(RecipK);
            r_s2_b    <= QuotWidth'(r_s1_b) * QuotWidth'(RecipK);
            r_s2_last <= r_s1_last;
        end
        if (s3_adv) begin
            r_s3_word <= n_word;
            r_s3_last <= r_s2_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_cnt   <= '0;
            r_shift <= '0;
            r_last  <= 1'b0;
        end else if (ser_load) begin
            r_busy  <= 1'b1;
            r_cnt   <= '0;
            r_shift <= r_s3_word;
            r_last  <= r_s3_last;
        end else if (out_fire) begin
            r_busy  <= !last_beat;
            r_cnt   <= r_cnt + CntWidth'(1);
            r_shift <= {r_shift[BitsPerPixel-2:0], 1'b0};
        end
    end

    assign o_bit.valid         = r_busy;
    assign o_bit.end_of_run    = trailer;
    assign o_bit.compare_value = trailer ? '0 :
                                 (r_shift[BitsPerPixel-1] ? r_duty_one : r_duty_zero);

endmodule

FILE: sim/tb_addressable_led_bit_encoder.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_addressable_led_bit_encoder
// self-checking bench for the brightness scaler and pwm bit serializer
// ----------------------------------------------------------------------------
// A directed table (register writes and pixels, some with hand-typed
// compare values) runs first, then several random phases, each with its own
// brightness and duty settings. Each untyped pixel is turned into its expected
// compare values by a local model of the encoder and queued. Each value the
// block hands out is checked against the oldest entry. Both channels stall
// at random, except during one phase where they run flat out.
module tb_addressable_led_bit_encoder;
    import aled_pkg::*;

    localparam int WatchdogLimit = 2000;
    localparam int DrainCycles   = 8;
    localparam int RandPhases    = 6;
    localparam int PixPerPhase   = 33;
    localparam int NumDirRows    = 23;

    // register index that decodes to nothing
    localparam logic [CfgIdxWidth-1:0] CfgIdxSpare = 2'd3;

    typedef struct packed {
        logic [7:0] compare_value;
        logic       end_of_run;
    } t_pwm_slot;

    typedef enum logic { ROW_CFG, ROW_PIX } t_row_kind;

    typedef struct packed {
        t_row_kind              kind;
        logic [CfgIdxWidth-1:0] idx;
        logic [CfgDatWidth-1:0] data;
        logic [7:0]             red;
        logic [7:0]             green;
        logic [7:0]             blue;
        logic                   last;
        logic                   typed;      // every bit gives typed_val
        logic [7:0]             typed_val;
    } t_stim_row;

    // kind, idx, data, red, green, blue, last, typed, typed_val
    localparam t_stim_row DirRows [NumDirRows] = '{
        // reset settings: 100 percent, one 50, zero 75
        '{ROW_PIX, CFG_BRIGHTNESS, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b1, 8'd75},
        '{ROW_PIX, CFG_BRIGHTNESS, 8'h00, 8'hFF, 8'hFF, 8'hFF, 1'b0, 1'b1, 8'd50},
        '{ROW_PIX, CFG_BRIGHTNESS, 8'h00, 8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b1, 8'd50},
        '{ROW_PIX, CFG_BRIGHTNESS, 8'h00, 8'h80, 8'h01, 8'hAA, 1'b1, 1'b0, 8'd0},
        '{ROW_PIX, CFG_BRIGHTNESS, 8'h00, 8'h55, 8'hAA, 8'h0F, 1'b0, 1'b0, 8'd0},
        // brightness zero blanks everything
        '{ROW_CFG, CFG_BRIGHTNESS, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 8'd0},
        '{ROW_PIX, CFG_BRIGHTNESS, 8'h00, 8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b1, 8'd75},
        // bit 7 of the data is dropped, leaving 127: saturation
        '{ROW_CFG, CFG_BRIGHTNESS, 8'hFF, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 8'd0},
        '{ROW_PIX, CFG_BRIGHTNESS, 8'h00, 8'hFF, 8'hFF, 8'hFF, 1'b0, 1'b1, 8'd50},
        '{ROW_PIX, CFG_BRIGHTNESS, 8'h00, 8'hC8, 8'h64, 8'h32, 1'b0, 1'b0, 8'd0},
        '{ROW_PIX, CFG_BRIGHTNESS, 8'h00, 8'h01, 8'h4F, 8'hC9, 1'b1, 1'b0, 8'd0},
        // half brightness, 1 rounds down to 0
        '{ROW_CFG, CFG_BRIGHTNESS, 8'd50, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 8'd0},
        '{ROW_PIX, CFG_BRIGHTNESS, 8'h00, 8'h01, 8'h01, 8'h01, 1'b0, 1'b1, 8'd75},
        '{ROW_PIX, CFG_BRIGHTNESS, 8'h00, 8'hFF, 8'h80, 8'h03, 1'b0, 1'b0, 8'd0},
        '{ROW_CFG, CFG_DUTY_ONE,   8'd0,  8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 8'd0},
        '{ROW_CFG, CFG_DUTY_ZERO,  8'd255, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 8'd0},
        '{ROW_PIX, CFG_BRIGHTNESS, 8'h00, 8'hF0, 8'h0F, 8'h3C, 1'b0, 1'b0, 8'd0},
        '{ROW_PIX, CFG_BRIGHTNESS, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1, 1'b1, 8'd255},
        '{ROW_CFG, CFG_DUTY_ONE,   8'd255, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 8'd0},
        '{ROW_CFG, CFG_DUTY_ZERO,  8'd0,  8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 8'd0},
        '{ROW_PIX, CFG_BRIGHTNESS, 8'h00, 8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b0, 8'd0},
        // write to an unused index must change nothing
        '{ROW_CFG, CfgIdxSpare,    8'hA5, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 8'd0},
        '{ROW_PIX, CFG_BRIGHTNESS, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b1, 8'd0}
    };

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_cfg_we;
    logic [CfgIdxWidth-1:0] i_cfg_idx;
    logic [CfgDatWidth-1:0] i_cfg_data;

    aled_pix_if pix_if ();
    aled_bit_if bit_if ();

    addressable_led_bit_encoder dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_pix      (pix_if),
        .o_bit      (bit_if)
    );

    // local copy of the encoder settings
    logic [PctWidth-1:0]  enc_brightness = BrightnessReset;
    logic [DutyWidth-1:0] enc_duty_one   = DutyOneReset;
    logic [DutyWidth-1:0] enc_duty_zero  = DutyZeroReset;

    t_pwm_slot expected_slots [$];
    int        mismatch_count = 0;
    int        quiet_cycles   = 0;
    bit        no_stall       = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [7:0] scale_level(logic [7:0] level);
        int unsigned lvl;
        int unsigned pct;
        int unsigned scaled;
        lvl    = 32'(level);
        pct    = 32'(enc_brightness);
        scaled = lvl * pct / 100;
        return (scaled > 255) ? 8'hFF : scaled[7:0];
    endfunction

    // queue the 24 bit periods (plus the idle slot after a last pixel)
    task automatic predict_pixel(input logic [7:0] red, input logic [7:0] green,
                                 input logic [7:0] blue, input logic last);
        logic [23:0] grb;
        grb = {scale_level(green), scale_level(red), scale_level(blue)};
        for (int i = 23; i >= 0; i--) begin
            expected_slots.push_back('{grb[i] ? enc_duty_one : enc_duty_zero, 1'b0});
        end
        if (last) begin
            expected_slots.push_back('{8'd0, 1'b1});
        end
    endtask

    function automatic logic [7:0] rand_level();
        if ($urandom_range(0, 7) == 0) begin
            return $urandom_range(0, 1) ? 8'hFF : 8'h00;
        end
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("error at %0t: %s got %0d want %0d", $realtime, what, got, want);
        mismatch_count++;
    endtask

    task automatic send_pixel(input logic [7:0] red, input logic [7:0] green,
                              input logic [7:0] blue, input logic last);
        if (!no_stall && $urandom_range(0, 99) < 27) begin
            pix_if.valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < 27);
        end
        pix_if.valid      <= 1'b1;
        pix_if.red        <= red;
        pix_if.green      <= green;
        pix_if.blue       <= blue;
        pix_if.last_pixel <= last;
        do @(posedge i_clk); while (!pix_if.ready);
    endtask

    task automatic write_reg(input logic [CfgIdxWidth-1:0] idx,
                             input logic [CfgDatWidth-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_BRIGHTNESS: enc_brightness = data[PctWidth-1:0];
            CFG_DUTY_ONE:   enc_duty_one   = data;
            CFG_DUTY_ZERO:  enc_duty_zero  = data;
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic wait_idle();
        pix_if.valid <= 1'b0;
        while (expected_slots.size() != 0) @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);
    endtask

    // bit channel sink: random backpressure and checking
    initial bit_if.ready = 1'b0;

    always @(posedge i_clk) begin
        t_pwm_slot want;
        if (!i_rst_n) begin
            bit_if.ready <= 1'b0;
        end else begin
            bit_if.ready <= no_stall || ($urandom_range(0, 99) >= 27);
            if (bit_if.valid && bit_if.ready) begin
                if (expected_slots.size() == 0) begin
                    report_mismatch("unexpected compare_value",
                                    int'(bit_if.compare_value), -1);
                end else begin
                    want = expected_slots.pop_front();
                    if (bit_if.compare_value !== want.compare_value) begin
                        report_mismatch("compare_value", int'(bit_if.compare_value),
                                        int'(want.compare_value));
                    end
                    if (bit_if.end_of_run !== want.end_of_run) begin
                        report_mismatch("end_of_run", int'(bit_if.end_of_run),
                                        int'(want.end_of_run));
                    end
                end
            end
        end
    end

    // watchdog on cycles with no transaction on either channel
    always @(posedge i_clk) begin
        if ((pix_if.valid && pix_if.ready) || (bit_if.valid && bit_if.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WatchdogLimit) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        t_stim_row      row;
        logic [7:0]     bri_data;
        logic [7:0]     one_data;
        logic [7:0]     zero_data;
        logic [7:0]     red;
        logic [7:0]     green;
        logic [7:0]     blue;
        logic           last;

        i_rst_n           = 1'b0;
        i_cfg_we          = 1'b0;
        i_cfg_idx         = CFG_BRIGHTNESS;
        i_cfg_data        = 8'd0;
        pix_if.valid      = 1'b0;
        pix_if.red        = 8'd0;
        pix_if.green      = 8'd0;
        pix_if.blue       = 8'd0;
        pix_if.last_pixel = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < NumDirRows; i++) begin
            row = DirRows[i];
            if (row.kind == ROW_CFG) begin
                wait_idle();
                write_reg(row.idx, row.data);
            end else begin
                if (row.typed) begin
                    for (int b = 0; b < 24; b++) begin
                        expected_slots.push_back('{row.typed_val, 1'b0});
                    end
                    if (row.last) begin
                        expected_slots.push_back('{8'd0, 1'b1});
                    end
                end else begin
                    predict_pixel(row.red, row.green, row.blue, row.last);
                end
                send_pixel(row.red, row.green, row.blue, row.last);
            end
        end

        for (int ph = 0; ph < RandPhases; ph++) begin
            wait_idle();
            case (ph)
                1:       bri_data[6:0] = 7'd127;
                2:       bri_data[6:0] = 7'd0;
                4:       bri_data[6:0] = 7'd100;
                default: bri_data[6:0] = 7'($urandom_range(0, 127));
            endcase
            bri_data[7] = 1'($urandom_range(0, 1));
            if (ph == 5) begin
                one_data  = 8'd0;
                zero_data = 8'd255;
            end else begin
                one_data  = 8'($urandom_range(0, 255));
                zero_data = 8'($urandom_range(0, 255));
            end
            write_reg(CFG_BRIGHTNESS, bri_data);
            write_reg(CFG_DUTY_ONE, one_data);
            write_reg(CFG_DUTY_ZERO, zero_data);
            if ($urandom_range(0, 1)) begin
                write_reg(CfgIdxSpare, 8'($urandom_range(0, 255)));
            end
            no_stall = (ph == 3);
            for (int n = 0; n < PixPerPhase; n++) begin
                red   = rand_level();
                green = rand_level();
                blue  = rand_level();
                // chains of a few pixels, each closed by a last pixel
                last  = ($urandom_range(0, 4) == 0) || (n == PixPerPhase - 1);
                predict_pixel(red, green, blue, last);
                send_pixel(red, green, blue, last);
            end
        end
        no_stall = 1'b0;

        wait_idle();
        repeat (4 * DrainCycles) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

FILE: files.f
sv/aled_pkg.sv
sv/aled_pix_if.sv
sv/aled_bit_if.sv
sv/addressable_led_bit_encoder.sv
sim/tb_addressable_led_bit_encoder.sv
